FILE: hdl/inode_extent_block_remapper_unit_macros.svh
// Assertion macros for the inode extent block remapper.
// No dependencies.
`ifndef INODE_EXTENT_BLOCK_REMAPPER_UNIT_MACROS_SVH
`define INODE_EXTENT_BLOCK_REMAPPER_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define IEBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the same cycle.
`define IEBR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/iebr_pkg.sv
// Package for the inode extent block remapper: beat types, status codes, controller command and status structs.
// No dependencies.
package iebr_pkg;
    localparam int unsigned TableEntriesDefault = 256;
    localparam int unsigned RemapW = 41;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_FULL       = 3'd2,
        ST_TRANSLATED = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef struct packed {
        logic        command;
        logic [31:0] inode_number;
        logic [31:0] block_number;
    } in_beat_t;

    typedef struct packed {
        logic [40:0] remapped_block;
        logic [2:0]  status;
        logic [8:0]  entry_count;
    } out_beat_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture input beat, clear sums
        logic scan_acc;  // compare/accumulate read data
        logic shift_wr;  // write read entry to index+1
        logic idx_dec;   // step index down
        logic idx_inc;   // save index as pos, move index to count
        logic fin_upd;   // write updated range at index
        logic fin_ins;   // write new entry at pos, bump count
        logic out_load;  // present result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;  // found position or reached end
        logic hit;
        logic full;
        logic is_xlate;
        logic shift_done; // index reached pos
    } stat_t;
endpackage

FILE: hdl/iebr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module iebr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/iebr_datapath.sv
// Datapath of the remapper: entry memory, index counter, span accumulator.
// Depends on iebr_pkg and iebr_ram.
module iebr_datapath
    import iebr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  in_beat,
    input  cmd_t      cmd,
    output stat_t     stat,
    output out_beat_t out_beat
);
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned RD = (TABLE_ENTRIES > 1) ? TABLE_ENTRIES : 2;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    in_beat_t             beat_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        idx_reg;     // scan position / shift source
    logic [CW-1:0]        pos_reg;
    logic                 hit_reg;
    logic                 found_reg;
    logic [31:0]          hmin_reg, hmax_reg;
    logic [RemapW-1:0]    sum_reg;
    out_beat_t            out_reg;
    logic [95:0]          rdata;
    logic [95:0]          wdata;
    logic [AW-1:0]        waddr, raddr;
    logic                 we;
    logic [31:0]          r_ino, r_min, r_max;
    logic [RemapW-1:0]    span;
    logic [31:0]          new_min, new_max;

    assign r_ino = rdata[95:64];
    assign r_min = rdata[63:32];
    assign r_max = rdata[31:0];
    assign span  = (r_min != 32'd0)
                 ? RemapW'(r_max) - RemapW'(r_min) + RemapW'(2)
                 : RemapW'(r_max) + RemapW'(1);

    // Range widening of a hit entry.
    always_comb begin
        new_min = hmin_reg;
        new_max = hmax_reg;
        if (beat_reg.block_number > hmax_reg) begin
            new_max = beat_reg.block_number;
        end else if (beat_reg.block_number < hmin_reg) begin
            new_min = beat_reg.block_number;
        end
    end

    // Memory write selection; a hit leaves the index on the matching entry.
    always_comb begin
        we    = 1'b0;
        waddr = AW'(pos_reg);
        wdata = {beat_reg.inode_number, beat_reg.block_number, beat_reg.block_number};
        raddr = AW'(idx_reg);
        if (cmd.shift_wr) begin
            we    = 1'b1;
            waddr = AW'(idx_reg + CW'(1));
            wdata = rdata;
        end else if (cmd.fin_upd) begin
            we    = 1'b1;
            waddr = AW'(idx_reg);
            wdata = {beat_reg.inode_number, new_min, new_max};
        end else if (cmd.fin_ins) begin
            we    = 1'b1;
        end
    end

    iebr_ram #(.WIDTH(96), .DEPTH(RD)) u_ram (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (raddr), .rdata (rdata)
    );

    // Status toward the controller.
    assign stat.scan_done  = found_reg || (idx_reg >= count_reg);
    assign stat.hit        = hit_reg;
    assign stat.full       = (count_reg >= CW'(TABLE_ENTRIES));
    assign stat.is_xlate   = beat_reg.command;
    assign stat.shift_done = (idx_reg == pos_reg);
    assign out_beat        = out_reg;

    // Hold the entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.fin_ins) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Scan, shift and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            beat_reg  <= in_beat;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
            sum_reg   <= '0;
        end
        if (cmd.scan_acc) begin
            if (r_ino < beat_reg.inode_number) begin
                sum_reg <= sum_reg + span;
                idx_reg <= idx_reg + CW'(1);
            end else begin
                found_reg <= 1'b1;
                hit_reg   <= (r_ino == beat_reg.inode_number);
                hmin_reg  <= r_min;
                hmax_reg  <= r_max;
            end
        end
        if (cmd.idx_inc) begin
            pos_reg <= idx_reg;
            idx_reg <= count_reg;
        end
        if (cmd.idx_dec) begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (cmd.out_load) begin
            out_reg.entry_count    <= 9'(count_reg + CW'(cmd.fin_ins));
            out_reg.remapped_block <= '0;
            if (beat_reg.command) begin
                if (hit_reg) begin
                    out_reg.status         <= ST_TRANSLATED;
                    out_reg.remapped_block <= sum_reg + RemapW'(beat_reg.block_number);
                end else begin
                    out_reg.status <= ST_NOT_FOUND;
                end
            end else if (hit_reg) begin
                out_reg.status <= ST_UPDATED;
            end else if (cmd.fin_ins) begin
                out_reg.status <= ST_INSERTED;
            end else begin
                out_reg.status <= ST_FULL;
            end
        end
    end
endmodule

FILE: hdl/iebr_ctrl.sv
// Controller of the remapper: handshake and sequencing of scan, shift, write.
// Depends on iebr_pkg.
module iebr_ctrl
    import iebr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_SRD   = 7'b0010000,
        S_SWR   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // Accept a beat only when idle and the result slot is free.
    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // Issue read at current index or stop the scan.
                if (stat.scan_done) begin
                    if (!stat.is_xlate && !stat.hit && !stat.full) begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DEC;
                    end else begin
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.scan_acc = 1'b1;
                state_next   = S_RD;
            end
            S_DEC: begin
                // Move entries at pos and above up by one, from the top.
                if (stat.shift_done) begin
                    state_next = S_FIN;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SRD: begin
                state_next = S_SWR;
            end
            S_SWR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_DEC;
            end
            S_FIN: begin
                if (!stat.is_xlate && stat.hit) begin
                    cmd.fin_upd = 1'b1;
                end else if (!stat.is_xlate && !stat.full) begin
                    cmd.fin_ins = 1'b1;
                end
                cmd.out_load = 1'b1;
                mvalid_next  = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

FILE: hdl/inode_extent_block_remapper_unit.sv
// Inode extent block remapper: sorted inode table with range tracking and
// address flattening. Entries are compared one read at a time from the entry
// memory; an insert then shifts the entries at and above its position up, one
// at a time, from the top. One beat at a time: the next is taken the cycle after
// the result beat leaves. Synchronous active-low reset empties the table; entry
// memory is not cleared.
module inode_extent_block_remapper_unit
    import iebr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);
    cmd_t  cmd;
    stat_t stat;

    iebr_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
        .m_valid (m_valid), .m_ready (m_ready), .stat (stat), .cmd (cmd)
    );

    iebr_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk (aclk), .aresetn (aresetn), .in_beat (s_data), .cmd (cmd),
        .stat (stat), .out_beat (m_data)
    );
endmodule

FILE: hdl/iebr_checker.sv
// Port-level checker for the remapper, bound to the top level.
// Depends on iebr_pkg and the macros header.
`include "inode_extent_block_remapper_unit_macros.svh"
module iebr_checker
    import iebr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);
    `IEBR_ASSERT_NEXT(a_no_accept_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `IEBR_ASSERT_NOW(a_no_accept_while_result, aclk, aresetn, m_valid, !s_ready)
    `IEBR_ASSERT_NOW(a_status_legal, aclk, aresetn, m_valid, m_data.status <= 3'd4)
    `IEBR_ASSERT_NOW(a_zero_unless_xlate, aclk, aresetn, m_valid && m_data.status != ST_TRANSLATED, m_data.remapped_block == '0)
endmodule

bind inode_extent_block_remapper_unit iebr_checker u_chk (
    .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
    .m_valid (m_valid), .m_ready (m_ready), .m_data (m_data)
);
